>>> design/smf_enc_pkg.sv
package smf_enc_pkg;

	localparam int TIME_W    = 63;
	localparam int TICK_W    = 32;
	localparam int MSG_W     = 24;
	localparam int BYTE_W    = 8;
	localparam int MAX_BYTES = 7;
	localparam int BCNT_W    = $clog2(MAX_BYTES + 1);
	localparam int VLQ_W     = 28;
	localparam int STEP_W    = $clog2(TIME_W);

	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic FUNC_MSG = 1'b0;
	localparam logic FUNC_EOT = 1'b1;

	localparam logic REG_START_TIME = 1'b0;
	localparam logic REG_TICK_NANOS = 1'b1;

	localparam logic [TICK_W-1:0] TICK_NANOS_RST = 32'd1000000;
	localparam logic [VLQ_W-1:0]  VLQ_MAX        = 28'h0FFFFFFF;

	localparam logic [3:0]        SYS_NIBBLE    = 4'hF;
	localparam logic [BYTE_W-1:0] ONE_DATA_MASK = 8'hE0;
	localparam logic [BYTE_W-1:0] ONE_DATA_CODE = 8'hC0;
	localparam logic [BYTE_W-1:0] META_BYTE     = 8'hFF;
	localparam logic [BYTE_W-1:0] EOT_TYPE      = 8'h2F;
	localparam logic [BYTE_W-1:0] EOT_LEN       = 8'h00;
	localparam logic [BYTE_W-1:0] VLQ_CONT      = 8'h80;

	// one queued event
	typedef struct packed {
		logic              eot;
		logic [TIME_W-1:0] elapsed;
		logic [MSG_W-1:0]  msg;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

>>> design/smf_track_event_encoder_top.sv
// Standard MIDI File track event encoder. Each input item on the s_ side is
// either a timestamped short message (s_tuser = 0) or an end-of-track request
// (s_tuser = 1); it comes out on the m_ side as the bytes of one track event:
// the delta-time as a variable-length quantity (clamped to 28 bits), then the
// message bytes with running status, or FF 2F 00 for end of track. m_tlast
// marks the final byte of each item. System statuses (F0 and up) are dropped
// on input and produce nothing. The tick is (event_time - start_time) divided
// by tick_nanos, held at or above the previous tick and saturated at 32 bits;
// end of track resets the tick and running status. The back end takes an item
// through a restoring divider that retires one quotient bit per cycle over
// the 63-bit elapsed time, works out the tick and delta, composes the bytes
// and sends them out, 2 to 7 per item, as the receiver takes them. A
// two-entry queue sits between the input side and the divider, so up to two
// items are taken while an earlier one is still being divided or drained.
// Registers (APB, 64-bit data): start_time at 0x0, tick_nanos at 0x8; write
// them only while the block is idle.
module smf_track_event_encoder_top import smf_enc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [87:0] s_tdata,   // [62:0] event_time, [86:63] message, [87] zero
	input  logic        s_tuser,   // func: 0 short message, 1 end of track
	// output bytes
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic        m_tlast,
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	logic [TIME_W-1:0] start_time_q;
	logic [TICK_W-1:0] tick_nanos_q;
	logic              cfg_wr;

	logic    push;
	logic    pop;
	entry_t  push_entry;
	entry_t  head;
	q_stat_t q_stat;

	// register file: only address bit 3 selects the register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_time_q <= '0;
			tick_nanos_q <= TICK_NANOS_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3])
				REG_START_TIME: start_time_q <= pwdata[TIME_W-1:0];
				REG_TICK_NANOS: tick_nanos_q <= pwdata[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3])
			REG_START_TIME: prdata = {1'b0, start_time_q};
			REG_TICK_NANOS: prdata = {32'd0, tick_nanos_q};
			default:        prdata = '0;
		endcase
	end

	// front: accept, drop system statuses, compute elapsed time
	smf_enc_front u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.func       (s_tuser),
		.event_time (s_tdata[62:0]),
		.message    (s_tdata[86:63]),
		.start_time (start_time_q),
		.q_stat     (q_stat),
		.push       (push),
		.push_entry (push_entry)
	);

	smf_enc_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat)
	);

	// back: divide, track ticks and running status, emit bytes
	smf_enc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_nanos (tick_nanos_q),
		.head       (head),
		.q_stat     (q_stat),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast)
	);

endmodule

>>> design/smf_enc_front.sv
module smf_enc_front import smf_enc_pkg::*; (
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic              func,
	input  logic [TIME_W-1:0] event_time,
	input  logic [MSG_W-1:0]  message,
	input  logic [TIME_W-1:0] start_time,
	input  q_stat_t           q_stat,
	output logic              push,
	output entry_t            push_entry
);

	logic is_sys;

	// system statuses are swallowed without reaching the queue
	assign is_sys   = (func == FUNC_MSG) && (message[7:4] == SYS_NIBBLE);
	assign s_tready = !q_stat.full;
	assign push     = s_tvalid && s_tready && !is_sys;

	always_comb begin
		push_entry.eot     = (func == FUNC_EOT);
		push_entry.elapsed = (event_time >= start_time) ? (event_time - start_time) : '0;
		push_entry.msg     = message;
	end

endmodule

>>> design/smf_enc_fifo.sv
module smf_enc_fifo import smf_enc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  entry_t  push_entry,
	input  logic    pop,
	output entry_t  head,
	output q_stat_t q_stat
);

	entry_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign head         = mem_q[rd_ptr_q];
	assign q_stat.full  = (count_q == QCNT_W'(QDEPTH));
	assign q_stat.empty = (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue count above depth");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count did not grow on push");

endmodule

>>> design/smf_enc_back.sv
module smf_enc_back import smf_enc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [TICK_W-1:0] tick_nanos,
	input  entry_t            head,
	input  q_stat_t           q_stat,
	output logic              pop,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [BYTE_W-1:0] m_tdata,
	output logic              m_tlast
);

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_DIV     = 3'd1;
	localparam logic [2:0] ST_CALC    = 3'd2;
	localparam logic [2:0] ST_COMPOSE = 3'd3;
	localparam logic [2:0] ST_EMIT    = 3'd4;

	logic [2:0]        state_q;
	logic [STEP_W-1:0] step_q;
	logic [TIME_W-1:0] dq_q;
	logic [TICK_W-1:0] rem_q;
	logic              eot_q;
	logic [MSG_W-1:0]  msg_q;
	logic [TICK_W-1:0] last_ticks_q;
	logic [BYTE_W-1:0] rs_q;
	logic [VLQ_W-1:0]  delta_q;
	logic [BYTE_W-1:0] buf_q [MAX_BYTES];
	logic [BCNT_W-1:0] byte_cnt_q;
	logic              m_tvalid_q;
	logic [BYTE_W-1:0] m_tdata_q;
	logic              m_tlast_q;

	// divider step
	logic [TICK_W:0]   rem_sh;
	logic              q_bit;
	logic [TICK_W:0]   rem_sub;
	// tick and delta
	logic [TICK_W-1:0] tick_sat;
	logic [TICK_W-1:0] now_tick;
	logic [TICK_W-1:0] delta_raw;
	// composition
	logic [6:0]        grp [4];
	logic [2:0]        nv;
	logic [BYTE_W-1:0] vb [4];
	logic [BYTE_W-1:0] tb [3];
	logic [1:0]        nt;
	logic [BYTE_W-1:0] status;
	logic [BYTE_W-1:0] buf_n [MAX_BYTES];
	logic [BCNT_W-1:0] total_n;
	logic [2:0]        k;
	logic              out_free;

	assign pop      = (state_q == ST_IDLE) && !q_stat.empty;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	always_comb begin
		rem_sh  = {rem_q, dq_q[TIME_W-1]};
		q_bit   = (rem_sh >= {1'b0, tick_nanos});
		rem_sub = rem_sh - {1'b0, tick_nanos};
	end

	always_comb begin
		tick_sat  = (|dq_q[TIME_W-1:TICK_W]) ? '1 : dq_q[TICK_W-1:0];
		now_tick  = (tick_sat < last_ticks_q) ? last_ticks_q : tick_sat;
		delta_raw = now_tick - last_ticks_q;
	end

	always_comb begin
		status = msg_q[7:0];
		grp[0] = delta_q[27:21];
		grp[1] = delta_q[20:14];
		grp[2] = delta_q[13:7];
		grp[3] = delta_q[6:0];
		vb[0]  = '0;
		vb[1]  = '0;
		vb[2]  = '0;
		vb[3]  = '0;
		priority if (grp[0] != '0) begin
			nv    = 3'd4;
			vb[0] = VLQ_CONT | {1'b0, grp[0]};
			vb[1] = VLQ_CONT | {1'b0, grp[1]};
			vb[2] = VLQ_CONT | {1'b0, grp[2]};
			vb[3] = {1'b0, grp[3]};
		end else if (grp[1] != '0) begin
			nv    = 3'd3;
			vb[0] = VLQ_CONT | {1'b0, grp[1]};
			vb[1] = VLQ_CONT | {1'b0, grp[2]};
			vb[2] = {1'b0, grp[3]};
		end else if (grp[2] != '0) begin
			nv    = 3'd2;
			vb[0] = VLQ_CONT | {1'b0, grp[2]};
			vb[1] = {1'b0, grp[3]};
		end else begin
			nv    = 3'd1;
			vb[0] = {1'b0, grp[3]};
		end

		tb[0] = '0;
		tb[1] = '0;
		tb[2] = '0;
		if (eot_q) begin
			tb[0] = META_BYTE;
			tb[1] = EOT_TYPE;
			tb[2] = EOT_LEN;
			nt    = 2'd3;
		end else if (status != rs_q) begin
			tb[0] = status;
			tb[1] = msg_q[15:8];
			tb[2] = msg_q[23:16];
			nt    = ((status & ONE_DATA_MASK) == ONE_DATA_CODE) ? 2'd2 : 2'd3;
		end else begin
			tb[0] = msg_q[15:8];
			tb[1] = msg_q[23:16];
			nt    = ((status & ONE_DATA_MASK) == ONE_DATA_CODE) ? 2'd1 : 2'd2;
		end

		for (int i = 0; i < MAX_BYTES; i++) begin
			k = 3'(i) - nv;
			if (3'(i) < nv) begin
				buf_n[i] = vb[i[1:0]];
			end else if (k < {1'b0, nt}) begin
				buf_n[i] = tb[k[1:0]];
			end else begin
				buf_n[i] = '0;
			end
		end
		total_n = BCNT_W'(nv) + BCNT_W'(nt);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			step_q       <= '0;
			last_ticks_q <= '0;
			rs_q         <= '0;
			byte_cnt_q   <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			// output register: load a byte when free, else drop a taken one
			if (state_q == ST_EMIT && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						step_q  <= STEP_W'(TIME_W - 1);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					step_q <= step_q - 1'b1;
					if (step_q == '0) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					last_ticks_q <= eot_q ? '0 : now_tick;
					state_q      <= ST_COMPOSE;
				end
				ST_COMPOSE: begin
					rs_q       <= eot_q ? '0 : msg_q[7:0];
					byte_cnt_q <= total_n;
					state_q    <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						byte_cnt_q <= byte_cnt_q - 1'b1;
						if (byte_cnt_q == BCNT_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			dq_q  <= head.elapsed;
			rem_q <= '0;
			eot_q <= head.eot;
			msg_q <= head.msg;
		end else if (state_q == ST_DIV) begin
			dq_q  <= {dq_q[TIME_W-2:0], q_bit};
			rem_q <= q_bit ? rem_sub[TICK_W-1:0] : rem_sh[TICK_W-1:0];
		end
		if (state_q == ST_CALC) begin
			delta_q <= (delta_raw > TICK_W'(VLQ_MAX)) ? VLQ_MAX : delta_raw[VLQ_W-1:0];
		end
		if (state_q == ST_COMPOSE) begin
			for (int i = 0; i < MAX_BYTES; i++) begin
				buf_q[i] <= buf_n[i];
			end
		end else if (state_q == ST_EMIT && out_free) begin
			m_tdata_q <= buf_q[0];
			m_tlast_q <= (byte_cnt_q == BCNT_W'(1));
			for (int i = 0; i < MAX_BYTES - 1; i++) begin
				buf_q[i] <= buf_q[i+1];
			end
			buf_q[MAX_BYTES-1] <= '0;
		end
	end

	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (byte_cnt_q == '0))
		else $error("idle with bytes pending");

	a_byte_bound: assert property (@(posedge clk) disable iff (!arst_n)
		byte_cnt_q <= BCNT_W'(MAX_BYTES))
		else $error("byte count above limit");

	a_eot_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMPOSE && eot_q) |=> (rs_q == '0 && last_ticks_q == '0))
		else $error("end of track left state behind");

endmodule

>>> verif/smf_event_byte_checker.sv
module smf_event_byte_checker import smf_enc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [87:0] s_tdata,   // [62:0] event_time, [86:63] message, [87] zero
	input  logic        s_tuser,   // func
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,   // [7:0] out_byte
	input  logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic        pready,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output int          mismatch_count,
	output int          bytes_pending
);

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
	} track_byte_t;

	track_byte_t track_bytes_due[$];
	track_byte_t due;

	// shadow of the block's registers and encoder state
	logic [TIME_W-1:0] start_ns;
	logic [TICK_W-1:0] tick_ns;
	logic [TICK_W-1:0] prev_tick;
	logic [BYTE_W-1:0] run_status;
	int                bad;

	function automatic logic [TICK_W-1:0] tick_count(input logic [TIME_W-1:0] t);
		logic [TIME_W-1:0] elapsed;
		logic [TIME_W-1:0] quot;
		elapsed = (t >= start_ns) ? t - start_ns : '0;
		if (tick_ns == '0)
			return '1;
		quot = elapsed / TIME_W'(tick_ns);
		if (quot > TIME_W'({TICK_W{1'b1}}))
			return '1;
		return quot[TICK_W-1:0];
	endfunction

	// bytes of one track event: delta VLQ, then message or end-of-track meta
	task automatic encode_event(input logic func, input logic [TIME_W-1:0] t,
			input logic [MSG_W-1:0] msg);
		logic [BYTE_W-1:0] seq [8];
		logic [TICK_W-1:0] now;
		logic [TICK_W-1:0] delta;
		logic [6:0]        grp;
		logic [BYTE_W-1:0] status;
		logic              started;
		int                n;
		n = 0;
		started = 1'b0;
		status = msg[7:0];
		// system status: dropped, tick not taken
		if (func == FUNC_MSG && status[7:4] == SYS_NIBBLE)
			return;
		now = tick_count(t);
		if (now < prev_tick)
			now = prev_tick;
		delta = now - prev_tick;
		prev_tick = now;
		if (delta > TICK_W'(VLQ_MAX))
			delta = TICK_W'(VLQ_MAX);
		for (int g = 3; g >= 0; g--) begin
			grp = delta[7*g +: 7];
			if (started || grp != '0 || g == 0) begin
				started = 1'b1;
				seq[n] = {1'b0, grp} | ((g > 0) ? VLQ_CONT : '0);
				n++;
			end
		end
		if (func == FUNC_EOT) begin
			seq[n] = META_BYTE;
			seq[n+1] = EOT_TYPE;
			seq[n+2] = EOT_LEN;
			n += 3;
			prev_tick = '0;
			run_status = '0;
		end else begin
			if (status != run_status) begin
				seq[n] = status;
				n++;
				run_status = status;
			end
			seq[n] = msg[15:8];
			n++;
			if ((status & ONE_DATA_MASK) != ONE_DATA_CODE) begin
				seq[n] = msg[23:16];
				n++;
			end
		end
		for (int k = 0; k < n; k++)
			track_bytes_due.push_back('{data: seq[k], last: (k == n - 1)});
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_bytes_due.delete();
			start_ns = '0;
			tick_ns = TICK_NANOS_RST;
			prev_tick = '0;
			run_status = '0;
			bad = 0;
			mismatch_count <= 0;
			bytes_pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[3] == REG_TICK_NANOS)
					tick_ns = pwdata[TICK_W-1:0];
				else
					start_ns = pwdata[TIME_W-1:0];
			end
			if (s_tvalid && s_tready)
				encode_event(s_tuser, s_tdata[TIME_W-1:0], s_tdata[TIME_W +: MSG_W]);
			if (m_tvalid && m_tready) begin
				if (track_bytes_due.size() == 0) begin
					if (bad < 10)
						$display("unexpected byte %02h last %0b", m_tdata, m_tlast);
					bad++;
				end else begin
					due = track_bytes_due.pop_front();
					if (due.data !== m_tdata || due.last !== m_tlast) begin
						if (bad < 10)
							$display("byte mismatch: expected %02h last %0b, got %02h last %0b",
								due.data, due.last, m_tdata, m_tlast);
						bad++;
					end
				end
			end
			mismatch_count <= bad;
			bytes_pending <= track_bytes_due.size();
		end
	end

endmodule

>>> verif/smf_track_event_encoder_top_test.sv
module smf_track_event_encoder_top_test;
	import smf_enc_pkg::*;

	localparam int                CYCLE_LIMIT   = 1000000;
	localparam int                SETTLE_CYCLES = 300;   // covers queue + divider latency
	localparam logic [3:0]        ADDR_START    = {REG_START_TIME, 3'b000};
	localparam logic [3:0]        ADDR_TICK     = {REG_TICK_NANOS, 3'b000};
	localparam logic [TIME_W-1:0] T_MAX         = '1;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [87:0] s_tdata;   // [62:0] event_time, [86:63] message, [87] zero
	logic        s_tuser;   // func: short message or end of track
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;   // [7:0] out_byte
	logic        m_tlast;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	int mismatch_count;
	int bytes_pending;
	int cycles;

	// idling controls for the sender and the receiver
	int   send_idle_pct;
	int   recv_idle_pct;
	int   hold_req;
	int   hold_left;
	logic calm;

	// sender's view of the configuration, used to aim timestamps, and its last status
	logic [TIME_W-1:0] cfg_start;
	logic [TICK_W-1:0] cfg_tick;
	logic [TIME_W-1:0] base_ns;
	logic [BYTE_W-1:0] last_status;

	smf_track_event_encoder_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	smf_event_byte_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tlast        (m_tlast),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.pready         (pready),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.mismatch_count (mismatch_count),
		.bytes_pending  (bytes_pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// byte receiver: random stall bursts, long hold-offs on request, none when calm
	initial begin
		m_tready = 1'b0;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req = 0;
				m_tready <= 1'b0;
				repeat (hold_left) @(posedge clk);
			end else if (!calm && $urandom_range(0, 99) < recv_idle_pct) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// two-phase APB write; the register takes the data on the access edge.
	// psel stays up so writes can follow back to back
	task automatic apb_write(input logic [3:0] addr, input logic [63:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic configure(input logic [TIME_W-1:0] start, input logic [TICK_W-1:0] tick);
		apb_write(ADDR_START, {1'b0, start});
		apb_write(ADDR_TICK, {32'b0, tick});
		psel <= 1'b0;
		penable <= 1'b0;
		cfg_start = start;
		cfg_tick = tick;
		base_ns = start;
	endtask

	// offer one item and hold it until the block takes it
	task automatic send_item(input logic func, input logic [TIME_W-1:0] t,
			input logic [MSG_W-1:0] msg);
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= {1'b0, msg, t};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic idle_gap();
		if (!calm && $urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic put(input logic func, input logic [TIME_W-1:0] t,
			input logic [MSG_W-1:0] msg);
		send_item(func, t, msg);
		idle_gap();
	endtask

	// stop sending, let every predicted byte arrive, then idle for the settle
	// margin before going on
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (bytes_pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// mostly moves forward by a tick count sized for 1..4 VLQ bytes or past
	// the clamp; sometimes random, before start, or backward in time
	function automatic logic [TIME_W-1:0] pick_time();
		logic [63:0] ticks;
		logic [63:0] t;
		int unsigned mode;
		mode = $urandom_range(0, 19);
		if (mode == 0) begin
			t = {$urandom, $urandom};
			return t[TIME_W-1:0];
		end
		if (mode == 1)
			return (cfg_start == '0) ? '0 : cfg_start >> $urandom_range(1, 62);
		if (mode == 2)
			return base_ns - TIME_W'($urandom_range(0, 255)) * TIME_W'(cfg_tick);
		case ($urandom_range(0, 5))
			0: ticks = 0;
			1: ticks = $urandom_range(1, 127);
			2: ticks = $urandom_range(128, 16383);
			3: ticks = $urandom_range(16384, 2097151);
			4: ticks = $urandom_range(2097152, 268435455);
			default: ticks = $urandom;
		endcase
		t = {1'b0, base_ns} + ticks * 64'(cfg_tick) + 64'($urandom_range(0, cfg_tick - 1));
		base_ns = t[TIME_W-1:0];
		if (base_ns[TIME_W-1])
			base_ns = cfg_start;
		return t[TIME_W-1:0];
	endfunction

	// favor repeating the last status so running status gets exercised
	function automatic logic [MSG_W-1:0] pick_msg();
		logic [BYTE_W-1:0] status;
		int unsigned r;
		r = $urandom_range(0, 19);
		if (r < 9)
			status = last_status;
		else if (r < 15)
			status = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom)};
		else if (r < 17)
			status = {SYS_NIBBLE, 4'($urandom)};
		else if (r < 19)
			status = 8'($urandom_range(0, 127));
		else
			status = 8'($urandom);
		if (status[7:4] != SYS_NIBBLE)
			last_status = status;
		return {16'($urandom), status};
	endfunction

	// one configuration, random items, optional long receiver hold-off and
	// a mid-phase full drain
	task automatic run_phase(input logic [TIME_W-1:0] start, input logic [TICK_W-1:0] tick,
			input int n_items, input int hold, input int pause_at);
		configure(start, tick);
		if (hold > 0)
			hold_req = hold;
		for (int i = 0; i < n_items; i++) begin
			send_item(($urandom_range(0, 11) == 0) ? FUNC_EOT : FUNC_MSG, pick_time(), pick_msg());
			if (i == pause_at)
				settle();
			else
				idle_gap();
		end
		settle();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tuser = FUNC_MSG;
		s_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cycles = 0;
		send_idle_pct = 20;
		recv_idle_pct = 20;
		hold_req = 0;
		calm = 1'b0;
		last_status = 8'h90;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// --- directed, default tick of 1 ms ---
		configure('0, TICK_NANOS_RST);
		// status 0 right after reset matches the cleared running status
		put(FUNC_MSG, '0, {8'h7F, 8'h40, 8'h00});
		put(FUNC_MSG, '0, {8'h64, 8'h3C, 8'h90});
		// same status again: dropped; 1-byte delta at its top value
		put(FUNC_MSG, 63'd127_000_000, {8'h00, 8'h3C, 8'h90});
		// program change, one data byte, 2-byte delta
		put(FUNC_MSG, 63'd255_000_000, {8'hAA, 8'h05, 8'hC5});
		// channel pressure, 3-byte delta
		put(FUNC_MSG, 63'd16_639_000_000, {8'h55, 8'h7F, 8'hD0});
		// system statuses: nothing out, tick untouched
		put(FUNC_MSG, 63'd99_000_000_000, {8'h12, 8'h34, 8'hF0});
		put(FUNC_MSG, T_MAX, {8'hFF, 8'hFF, 8'hFF});
		// earlier timestamp: tick held, delta 0
		put(FUNC_MSG, 63'd1_000_000, {8'h40, 8'h00, 8'hE3});
		// data-range status taken as a message with two data bytes
		put(FUNC_MSG, 63'd17_000_000_000, {8'hFF, 8'hFF, 8'h7F});
		// max time: tick saturates, delta clamps to 28 bits
		put(FUNC_MSG, T_MAX, {8'h7F, 8'h07, 8'hB0});
		put(FUNC_EOT, '0, '0);
		put(FUNC_MSG, 63'd5_000_000, {8'h11, 8'h22, 8'h00});
		put(FUNC_MSG, T_MAX, {8'h01, 8'h02, 8'hA0});
		put(FUNC_EOT, T_MAX, '1);
		put(FUNC_MSG, 63'd3_000_000, {8'h00, 8'h00, 8'hF8});
		settle();

		// --- directed, 1 ns ticks, start after zero ---
		configure(63'd1000, 32'd1);
		// timestamp before start counts as zero
		put(FUNC_MSG, 63'd500, {8'h40, 8'h3C, 8'h80});
		// delta exactly at the VLQ ceiling, then past it
		put(FUNC_MSG, 63'd1000 + 63'h0FFF_FFFF, {8'h41, 8'h3D, 8'h80});
		put(FUNC_MSG, 63'd1000 + 63'h0FFF_FFFF + 63'h1000_0005, {8'h42, 8'h3E, 8'h81});
		put(FUNC_EOT, '0, '0);
		settle();

		// --- random phases ---
		send_idle_pct = 30;
		recv_idle_pct = 30;
		run_phase(T_MAX, '1, 25, 0, -1);

		// pressure: receiver holds off while the sender streams back to back
		send_idle_pct = 0;
		recv_idle_pct = 10;
		run_phase(TIME_W'({$urandom, $urandom} >> 24), TICK_W'($urandom_range(1, 5000)),
			80, 800, -1);

		// sender waits for a full drain midway
		send_idle_pct = 25;
		recv_idle_pct = 25;
		run_phase('0, 32'd1, 80, 0, 40);

		// a stretch with no idling at all
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_phase(TIME_W'({$urandom, $urandom}), TICK_W'($urandom_range(1, 32'hFFFF_FFFF)),
			60, 0, -1);

		send_idle_pct = 40;
		recv_idle_pct = 40;
		run_phase(TIME_W'($urandom_range(0, 1000000)), TICK_W'($urandom_range(1, 1000000)),
			80, 0, -1);

		// last part runs without idling on either side
		calm = 1'b1;
		run_phase('0, TICK_NANOS_RST, 80, 0, -1);

		if (mismatch_count == 0 && bytes_pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
